[rtl/core/ddp_pkg.sv]
package ddp_pkg;

  // Reflected CRC-64 polynomial and its start value.
  localparam logic [63:0] CRC_POLY = 64'h95AC9329AC4BC9B5;
  localparam logic [63:0] CRC_INIT = 64'hFFFFFFFFFFFFFFFF;

  // Characters of interest.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_THREE = 8'h33;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  // Digits from six upward take the long code 1100..1111.
  localparam logic [3:0] LONG_DIGIT_MIN = 4'd6;
  localparam logic [3:0] LONG_CODE_BIAS = 4'd6;
  localparam logic [2:0] SHORT_CODE_LEN = 3'd3;
  localparam logic [2:0] LONG_CODE_LEN  = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE       = 2'd0;
  localparam logic [1:0] KIND_TRAILER    = 2'd1;
  localparam logic [1:0] KIND_BAD_PREFIX = 2'd2;

  // Prefix phase codes.
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_DOT   = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  packed_byte;
    logic [63:0] crc_value;
    logic [63:0] char_count;
    logic        end_of_run;
  } out_item_t;

  // All results caused by one character, in delivery order:
  // full code byte, residual byte, then trailer or prefix error.
  typedef struct packed {
    logic        has_full;
    logic [7:0]  full_byte;
    logic        has_resid;
    logic [7:0]  resid_byte;
    logic        has_final;
    logic        final_err;
    logic [63:0] crc;
    logic [63:0] count;
  } rec_t;

  // One character through the reflected CRC-64.
  function automatic logic [63:0] crc64_byte(logic [63:0] crc, logic [7:0] ch);
    logic [63:0] t;
    t = {56'd0, crc[7:0] ^ ch};
    for (int k = 0; k < 8; k++) begin
      t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
    end
    return t ^ (crc >> 8);
  endfunction

endpackage

[rtl/core/decimal_digit_packer_crc64.sv]
// Decimal digit packer with CRC-64.
// Input channel (in_valid_i/in_ready_o/in_item_i) takes one character per
// transfer with a flag marking the last character of a stream. Digits are
// packed MSB-first into bytes on the output channel (out_valid_o/out_ready_i/
// out_item_o); the last character also yields a padded residual byte if bits
// remain and a trailer with the CRC-64 and character count. In pi mode a stream must
// open with "3." or it ends with a single bad-prefix result.
// The configuration channel (cfg_valid_i/cfg_ready_o/cfg_pi_mode_i) sets
// pi mode; it is always ready. It must be written only while the block is idle;
// the block itself does not enforce this. A character passes the input
// register, then the result register, before its first result appears.
// Throughput: one character per cycle while the receiver keeps up. The single
// result register hands out one result per transfer, so after a character that
// gives two or three results the next character with results waits for them.
// Reset clears pi mode and all stream state; no result is pending after it.
// When the receiver stalls, the result register holds, characters without
// results keep flowing, and the next character with results waits.
module decimal_digit_packer_crc64 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_pi_mode_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ddp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ddp_pkg::out_item_t out_item_o
);
  import ddp_pkg::*;

  logic pi_mode_q;
  logic rec_push;
  logic rec_free;
  rec_t rec;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pi_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pi_mode_q <= cfg_pi_mode_i;
    end
  end

  ddp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pi_mode_i  (pi_mode_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .rec_push_o (rec_push),
    .rec_o      (rec),
    .rec_free_i (rec_free)
  );

  ddp_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_push_i  (rec_push),
    .rec_i       (rec),
    .rec_free_o  (rec_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // A record only enters the result register when it is free.
  a_push_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push |-> rec_free) else $error("record pushed into busy result register");

  // A pushed record always presents a result in the next cycle.
  a_push_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push |=> out_valid_o) else $error("pushed record not presented");

  // Only trailers and prefix errors close a stream.
  a_end_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.end_of_run == (out_item_o.kind != KIND_BYTE)))
    else $error("end_of_run does not match result kind");

endmodule

[rtl/core/ddp_core.sv]
module ddp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pi_mode_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ddp_pkg::in_item_t in_item_i,
  output logic              rec_push_o,
  output ddp_pkg::rec_t     rec_o,
  input  logic              rec_free_i
);
  import ddp_pkg::*;

  // Input register.
  logic       item_v_q;
  in_item_t   item_q;

  // Stream state.
  logic [6:0]  accum_q, accum_d;
  logic [2:0]  filled_q, filled_d;
  logic [63:0] crc_q, crc_d;
  logic [63:0] len_q, len_d;
  logic [1:0]  phase_q, phase_d;
  logic        bad_q, bad_d;

  logic        consume;
  logic        any_result;
  rec_t        rec;

  // Working values for the packing path.
  logic [7:0]  diff;
  logic [3:0]  digit;
  logic        is_digit;
  logic        long_code;
  logic [2:0]  code_len;
  logic [3:0]  code;
  logic [10:0] comb;
  logic [3:0]  total;
  logic [2:0]  rem;
  logic [7:0]  expect_ch;
  logic [3:0]  pad_shift;

  always_comb begin
    diff      = item_q.char_in - CHAR_ZERO;
    digit     = diff[3:0];
    is_digit  = item_q.char_in inside {[CHAR_ZERO:CHAR_NINE]};
    long_code = digit >= LONG_DIGIT_MIN;
    code_len  = long_code ? LONG_CODE_LEN : SHORT_CODE_LEN;
    code      = long_code ? digit + LONG_CODE_BIAS : digit;
    comb      = ({4'd0, accum_q} << code_len) | {7'd0, code};
    total     = {1'b0, filled_q} + {1'b0, code_len};
    rem       = total[2:0];
    expect_ch = (phase_q == PH_START) ? CHAR_THREE : CHAR_DOT;
    pad_shift = 4'd0;

    accum_d  = accum_q;
    filled_d = filled_q;
    crc_d    = crc_q;
    len_d    = len_q;
    phase_d  = phase_q;
    bad_d    = bad_q;
    rec      = '0;

    if (bad_q) begin
      // Rest of a failed stream is dropped up to its last character.
      if (item_q.last_in) begin
        bad_d = 1'b0;
        phase_d = PH_START;
      end
    end else if (phase_q != PH_DATA && pi_mode_i) begin
      // Prefix check.
      if (item_q.char_in != expect_ch || item_q.last_in) begin
        rec.has_final = 1'b1;
        rec.final_err = 1'b1;
        if (item_q.last_in) begin
          phase_d = PH_START;
        end else begin
          bad_d = 1'b1;
        end
      end else begin
        phase_d = phase_q + 2'd1;
      end
    end else begin
      // Data character.
      phase_d = PH_DATA;
      crc_d   = crc64_byte(crc_q, item_q.char_in);
      len_d   = len_q + 64'd1;
      if (is_digit) begin
        if (total[3]) begin
          rec.has_full  = 1'b1;
          rec.full_byte = 8'(comb >> rem);
          accum_d       = comb[6:0] & ((7'd1 << rem) - 7'd1);
          filled_d      = rem;
        end else begin
          accum_d  = comb[6:0];
          filled_d = total[2:0];
        end
      end
      if (item_q.last_in) begin
        pad_shift = 4'd8 - {1'b0, filled_d};
        rec.has_resid  = filled_d != 3'd0;
        rec.resid_byte = 8'({1'b0, accum_d} << pad_shift);
        rec.has_final  = 1'b1;
        rec.crc        = crc_d;
        rec.count      = len_d;
        accum_d  = '0;
        filled_d = '0;
        crc_d    = CRC_INIT;
        len_d    = '0;
        phase_d  = PH_START;
      end
    end
  end

  // An item with no result never waits for the result stage.
  assign any_result = rec.has_full | rec.has_resid | rec.has_final;
  assign consume    = item_v_q && (rec_free_i || !any_result);
  assign in_ready_o = !item_v_q || consume;
  assign rec_push_o = consume && any_result;
  assign rec_o      = rec;

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
    end else if (in_ready_o) begin
      item_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  // Stream state update on each processed character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q  <= '0;
      filled_q <= '0;
      crc_q    <= CRC_INIT;
      len_q    <= '0;
      phase_q  <= PH_START;
      bad_q    <= 1'b0;
    end else if (consume) begin
      accum_q  <= accum_d;
      filled_q <= filled_d;
      crc_q    <= crc_d;
      len_q    <= len_d;
      phase_q  <= phase_d;
      bad_q    <= bad_d;
    end
  end

endmodule

[rtl/core/ddp_out.sv]
module ddp_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rec_push_i,
  input  ddp_pkg::rec_t      rec_i,
  output logic               rec_free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ddp_pkg::out_item_t out_item_o
);
  import ddp_pkg::*;

  // Pending-result flags and held payload.
  logic        full_q, resid_q, final_q;
  logic        final_err_q;
  logic [7:0]  full_byte_q, resid_byte_q;
  logic [63:0] crc_q, count_q;
  logic        out_fire;
  logic        one_left;

  assign out_valid_o = full_q | resid_q | final_q;
  assign out_fire    = out_valid_o && out_ready_i;
  assign one_left    = $countones({full_q, resid_q, final_q}) == 1;
  assign rec_free_o  = !out_valid_o || (out_fire && one_left);

  // Present the earliest pending result.
  always_comb begin
    out_item_o = '0;
    if (full_q) begin
      out_item_o.kind        = KIND_BYTE;
      out_item_o.packed_byte = full_byte_q;
    end else if (resid_q) begin
      out_item_o.kind        = KIND_BYTE;
      out_item_o.packed_byte = resid_byte_q;
    end else if (final_q) begin
      out_item_o.end_of_run = 1'b1;
      if (final_err_q) begin
        out_item_o.kind = KIND_BAD_PREFIX;
      end else begin
        out_item_o.kind       = KIND_TRAILER;
        out_item_o.crc_value  = crc_q;
        out_item_o.char_count = count_q;
      end
    end
  end

  // Flags: load a new record, or retire the front result on a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q  <= 1'b0;
      resid_q <= 1'b0;
      final_q <= 1'b0;
    end else if (rec_push_i) begin
      full_q  <= rec_i.has_full;
      resid_q <= rec_i.has_resid;
      final_q <= rec_i.has_final;
    end else if (out_fire) begin
      if (full_q) begin
        full_q <= 1'b0;
      end else if (resid_q) begin
        resid_q <= 1'b0;
      end else begin
        final_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_push_i) begin
      full_byte_q  <= rec_i.full_byte;
      resid_byte_q <= rec_i.resid_byte;
      final_err_q  <= rec_i.final_err;
      crc_q        <= rec_i.crc;
      count_q      <= rec_i.count;
    end
  end

endmodule
